// ----- hw/rtl/min_string_rotation_core_assert.svh -----
// Assertion helpers for the rotation core.
`ifndef MIN_STRING_ROTATION_CORE_ASSERT_SVH
`define MIN_STRING_ROTATION_CORE_ASSERT_SVH

// Same-cycle implication.
`define MSR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("min_string_rotation_core: check failed");

// Next-cycle implication.
`define MSR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("min_string_rotation_core: check failed");

`endif

// ----- hw/rtl/msr_pkg.sv -----
`timescale 1ns / 1ps

package msr_pkg;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last_char;
    } in_t;

    typedef struct packed {
        logic [11:0] best_start;
        logic [12:0] string_length;
        logic        overflow;
    } out_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_CMP  = 3'b100
    } search_state_t;

endpackage

// ----- hw/rtl/min_string_rotation_core.sv -----
`timescale 1ns / 1ps
// Least cyclic rotation finder.
// Request channel: a byte request (char_in, last_char) is taken at a rising
// edge with start high and busy low. Bytes load one per cycle while busy is
// low into the character memory; bytes past MAX_LEN are dropped and flag
// overflow. On the request with last_char set, busy rises and the two-pointer
// search walks the stored string. Each comparison step is a memory read
// followed by a compare.
// Result channel: done is high for exactly one cycle with result holding
// best_start, string_length and overflow. busy falls in that same cycle, so
// the next byte may be taken while the result is shown.
// The receiver cannot stall; the result must be taken when done is high.
// Reset clears the length count, overflow flag and control state. The
// character memory is not cleared; only bytes of the current string are read.
`include "min_string_rotation_core_assert.svh"

module min_string_rotation_core #(
    parameter int MAX_LEN = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  msr_pkg::in_t req_data,
    output logic         done,
    output msr_pkg::out_t result
);

    import msr_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = AW + 1;

    logic [LW-1:0] length_reg, length_next;
    logic          overflow_reg, overflow_next;
    logic          busy_reg, busy_next;
    logic          done_reg;
    logic [LW-1:0] n_reg, n_next;
    logic          ovf_lat_reg, ovf_lat_next;
    out_t          result_reg;

    logic          accept;
    logic          has_room;
    logic [LW-1:0] length_inc;
    logic          go;

    logic [AW-1:0] raddr_a, raddr_b;
    logic [7:0]    rdata_a, rdata_b;
    logic          search_done;
    logic [AW+1:0] best;

    assign accept     = start && !busy_reg;
    assign has_room   = length_reg < LW'(MAX_LEN);
    assign length_inc = has_room ? length_reg + LW'(1) : length_reg;
    assign go         = accept && req_data.last_char;

    always_comb
    begin
        length_next   = length_reg;
        overflow_next = overflow_reg;
        busy_next     = busy_reg;
        n_next        = n_reg;
        ovf_lat_next  = ovf_lat_reg;
        if (accept)
        begin
            length_next   = length_inc;
            overflow_next = overflow_reg || !has_room;
            if (req_data.last_char)
            begin
                n_next        = length_inc;
                ovf_lat_next  = overflow_reg || !has_room;
                length_next   = '0;
                overflow_next = 1'b0;
                busy_next     = 1'b1;
            end
        end
        if (search_done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg   <= '0;
            overflow_reg <= 1'b0;
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            length_reg   <= length_next;
            overflow_reg <= overflow_next;
            busy_reg     <= busy_next;
            done_reg     <= search_done;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        ovf_lat_reg <= ovf_lat_next;
        if (search_done)
        begin
            result_reg.best_start    <= 12'(best);
            result_reg.string_length <= 13'(n_reg);
            result_reg.overflow      <= ovf_lat_reg;
        end
    end

    msr_store #(
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .we      (accept && has_room),
        .waddr   (length_reg[AW-1:0]),
        .wdata   (req_data.char_in),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    msr_search #(
        .AW (AW),
        .LW (LW)
    ) u_search (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go),
        .n       (length_inc),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .done    (search_done),
        .best    (best)
    );

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    `MSR_ASSERT_SAME(a_done_after_busy, done_reg, $past(busy_reg) && !busy_reg)
    `MSR_ASSERT_NEXT(a_last_sets_busy, go, busy_reg)
    `MSR_ASSERT_SAME(a_length_bound, 1'b1, length_reg <= LW'(MAX_LEN))
    `MSR_ASSERT_SAME(a_overflow_full, overflow_reg, length_reg == LW'(MAX_LEN))

endmodule

// ----- hw/rtl/msr_store.sv -----
`timescale 1ns / 1ps

module msr_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [7:0]    rdata_a,
    output logic [7:0]    rdata_b
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- hw/rtl/msr_search.sv -----
`timescale 1ns / 1ps

module msr_search #(
    parameter int AW = 12,
    parameter int LW = 13
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  logic [LW-1:0] n,
    input  logic [7:0]    rdata_a,
    input  logic [7:0]    rdata_b,
    output logic [AW-1:0] raddr_a,
    output logic [AW-1:0] raddr_b,
    output logic          done,
    output logic [AW+1:0] best
);

    import msr_pkg::*;

    localparam int PW = AW + 2;

    search_state_t state_reg, state_next;
    logic [PW-1:0] a_reg, a_next;
    logic [PW-1:0] b_reg, b_next;
    logic [PW-1:0] k_reg, k_next;
    logic [PW-1:0] n_reg, n_next;

    logic [PW-1:0] pa, pb, pa_w, pb_w;
    logic [PW-1:0] a_upd, b_upd;
    logic          running;

    // positions in the doubled string, folded back once
    assign pa      = a_reg + k_reg;
    assign pb      = b_reg + k_reg;
    assign pa_w    = (pa >= n_reg) ? pa - n_reg : pa;
    assign pb_w    = (pb >= n_reg) ? pb - n_reg : pb;
    assign raddr_a = pa_w[AW-1:0];
    assign raddr_b = pb_w[AW-1:0];

    assign running = (a_reg < n_reg) && (b_reg < n_reg) && (k_reg < n_reg);
    assign best    = (a_reg < b_reg) ? a_reg : b_reg;

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        done       = 1'b0;
        a_upd      = a_reg;
        b_upd      = b_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    n_next     = PW'(n);
                    a_next     = '0;
                    b_next     = PW'(1);
                    k_next     = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (running)
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CMP:
            begin
                if (rdata_a == rdata_b)
                begin
                    k_next = k_reg + PW'(1);
                end
                else
                begin
                    if (rdata_a > rdata_b)
                    begin
                        a_upd = a_reg + k_reg + PW'(1);
                    end
                    else
                    begin
                        b_upd = b_reg + k_reg + PW'(1);
                    end
                    a_next = a_upd;
                    b_next = (a_upd == b_upd) ? b_upd + PW'(1) : b_upd;
                    k_next = '0;
                end
                state_next = S_READ;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
        n_reg <= n_next;
    end

endmodule
